// File: design/button_debounce_long_press_defines.svh
// assertion macros shared by the debouncer lanes and the output buffer
// depends on nothing; included by files that carry concurrent checks
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication under reset
`define BDLP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication under reset
`define BDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define BDLP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BDLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/bdlp_pkg.sv
// constants, register codes and types of the button debouncer
// no dependencies; imported by every module of the block
package bdlp_pkg;

    // field and state widths
    localparam int FIELD_W    = 7;
    localparam int TIME_W     = 32;
    localparam int MS_W       = 16;
    localparam int HIST_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int NUM_BUTTONS_DEFAULT = 7;

    // history patterns
    localparam logic [HIST_W-1:0] PATTERN_MASK = 16'hF03F;
    localparam logic [HIST_W-1:0] RISE_PATTERN = 16'h003F;
    localparam logic [HIST_W-1:0] FALL_PATTERN = 16'hF000;
    localparam logic [HIST_W-1:0] HIST_ONES    = 16'hFFFF;
    localparam logic [HIST_W-1:0] HIST_ZEROS   = 16'h0000;

    // register reset values
    localparam logic [FIELD_W-1:0] ACTIVE_LOW_RESET = 7'd127;
    localparam logic [MS_W-1:0]    LONG_PRESS_RESET = 16'd1000;
    localparam logic [MS_W-1:0]    REPEAT_RESET     = 16'd100;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd2;

    // timing registers seen by every lane
    typedef struct packed {
        logic [MS_W-1:0] long_press_ms;
        logic [MS_W-1:0] repeat_ms;
    } timing_cfg_t;

    // polarity of a lane after reset, zero for lanes beyond the field
    function automatic logic lane_reset_low(input int lane);
        logic r;
        r = 1'b0;
        for (int k = 0; k < FIELD_W; k++) begin
            if (k == lane) begin
                r = ACTIVE_LOW_RESET[k];
            end
        end
        return r;
    endfunction

endpackage

// File: design/bdlp_lane.sv
// one button lane: sample history, pressed flag and held deadline
// depends on bdlp_pkg and the assertion macro header
`include "button_debounce_long_press_defines.svh"

module bdlp_lane #(
    parameter logic RESET_LOW = 1'b1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        level,
    input  logic                        low,
    input  logic [bdlp_pkg::TIME_W-1:0] now_ms,
    input  bdlp_pkg::timing_cfg_t       timing,
    output logic                        press_event
);
    import bdlp_pkg::*;

    logic [HIST_W-1:0] history_reg, history_next;
    logic              pressed_flag_reg, pressed_flag_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;

    logic [HIST_W-1:0] shifted;
    logic              rise;
    logic              fall;
    logic              released;
    logic              held_due;
    logic              press_seen;

    // shift in the level and test both settled patterns
    assign shifted = {history_reg[HIST_W-2:0], level};
    assign rise    = (shifted & PATTERN_MASK) == RISE_PATTERN;
    assign fall    = (shifted & PATTERN_MASK) == FALL_PATTERN;

    assign released   = low ? rise : fall;
    assign press_seen = low ? fall : rise;
    assign held_due   = pressed_flag_reg && (now_ms >= deadline_reg);

    // release first, then the held deadline, then a new press
    always_comb
    begin
        history_next      = history_reg;
        pressed_flag_next = pressed_flag_reg;
        deadline_next     = deadline_reg;
        press_event       = 1'b0;
        if (step)
        begin
            history_next = shifted;
            if (released)
            begin
                history_next      = low ? HIST_ONES : HIST_ZEROS;
                pressed_flag_next = 1'b0;
            end
            else if (held_due)
            begin
                deadline_next = deadline_reg + {{(TIME_W-MS_W){1'b0}}, timing.repeat_ms};
            end
            else if (press_seen)
            begin
                history_next = low ? HIST_ZEROS : HIST_ONES;
                if (!pressed_flag_reg)
                begin
                    pressed_flag_next = 1'b1;
                    deadline_next     = now_ms + {{(TIME_W-MS_W){1'b0}}, timing.long_press_ms};
                    press_event       = 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg      <= RESET_LOW ? HIST_ONES : HIST_ZEROS;
            pressed_flag_reg <= 1'b0;
            deadline_reg     <= '0;
        end
        else
        begin
            history_reg      <= history_next;
            pressed_flag_reg <= pressed_flag_next;
            deadline_reg     <= deadline_next;
        end
    end

    // a press is only reported from the released state and then latches
    `BDLP_ASSERT_IMPL(a_event_from_idle, clk, rst_n, press_event, !pressed_flag_reg)
    `BDLP_ASSERT_NEXT(a_event_sets_flag, clk, rst_n, press_event, pressed_flag_reg)
    `BDLP_ASSERT_NEXT(a_release_clears, clk, rst_n, step && released, !pressed_flag_reg)

endmodule

// File: design/bdlp_merge.sv
// merges lane press events into the result mask behind a two-entry output buffer
// depends on bdlp_pkg and the assertion macro header
`include "button_debounce_long_press_defines.svh"

module bdlp_merge #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [NUM_BUTTONS-1:0]       events,
    output logic                         ready,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [bdlp_pkg::FIELD_W-1:0] press_mask
);
    import bdlp_pkg::*;

    logic [FIELD_W-1:0] merged;
    logic [FIELD_W-1:0] out_data_reg;
    logic               out_valid_reg;
    logic [FIELD_W-1:0] skid_data_reg;
    logic               skid_valid_reg;
    logic               pop;

    // gather lane events into the field, buttons past the field are dropped
    for (genvar k = 0; k < FIELD_W; k++)
    begin : g_merge
        if (k < NUM_BUTTONS)
        begin : g_lane
            assign merged[k] = events[k];
        end
        else
        begin : g_none
            assign merged[k] = 1'b0;
        end
    end

    assign ready        = !skid_valid_reg;
    assign pop          = out_valid_reg && result_ready;
    assign result_valid = out_valid_reg;
    assign press_mask   = out_data_reg;

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!push)
            begin
                out_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // payload moves without reset
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else if (push)
            begin
                out_data_reg <= merged;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_data_reg <= merged;
            end
            else
            begin
                out_data_reg <= merged;
            end
        end
    end

    // skid only holds a request behind a full output register
    `BDLP_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `BDLP_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, push, !skid_valid_reg)

endmodule

// File: design/button_debounce_long_press.sv
// top level of the button debouncer with long-press timing
// depends on bdlp_pkg, bdlp_lane and bdlp_merge
//
// Debounces up to NUM_BUTTONS buttons in parallel, one lane per button, from
// scan-tick requests that carry the raw levels and the millisecond time. Each
// accepted request yields exactly one result, the mask of new presses, which
// is registered in the output buffer. The block takes one request every
// cycle: all lanes update in the same cycle (a 32-bit compare and add per
// lane) and a two-entry output buffer keeps taking requests while a result
// waits, so item_ready only drops when both entries are full. Configuration
// writes are taken at any cycle (cfg_ready is always high) and should be
// made while no request is in flight. Changing the polarity mask does not
// reload the histories.
module button_debounce_long_press #(
    parameter int NUM_BUTTONS = bdlp_pkg::NUM_BUTTONS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [bdlp_pkg::FIELD_W-1:0]    levels,
    input  logic [bdlp_pkg::TIME_W-1:0]     now_ms,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [bdlp_pkg::FIELD_W-1:0]    press_mask,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bdlp_pkg::*;

    logic [FIELD_W-1:0]     active_low_reg;
    timing_cfg_t            timing_reg;
    logic                   step;
    logic [NUM_BUTTONS-1:0] lane_level;
    logic [NUM_BUTTONS-1:0] lane_low;
    logic [NUM_BUTTONS-1:0] lane_event;

    assign cfg_ready = 1'b1;
    assign step      = item_valid && item_ready;

    // configuration register decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_low_reg           <= ACTIVE_LOW_RESET;
            timing_reg.long_press_ms <= LONG_PRESS_RESET;
            timing_reg.repeat_ms     <= REPEAT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_LOW: active_low_reg           <= cfg_data[FIELD_W-1:0];
                CFG_LONG_PRESS: timing_reg.long_press_ms <= cfg_data[MS_W-1:0];
                CFG_REPEAT:     timing_reg.repeat_ms     <= cfg_data[MS_W-1:0];
                default:        ;
            endcase
        end
    end

    // one lane per button
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        if (i < FIELD_W)
        begin : g_field
            assign lane_level[i] = levels[i];
            assign lane_low[i]   = active_low_reg[i];
        end
        else
        begin : g_beyond
            assign lane_level[i] = 1'b0;
            assign lane_low[i]   = 1'b0;
        end

        bdlp_lane #(
            .RESET_LOW (lane_reset_low(i))
        ) u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .step        (step),
            .level       (lane_level[i]),
            .low         (lane_low[i]),
            .now_ms      (now_ms),
            .timing      (timing_reg),
            .press_event (lane_event[i])
        );
    end

    // merge and output buffer
    bdlp_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (step),
        .events       (lane_event),
        .ready        (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .press_mask   (press_mask)
    );

endmodule
